FILE: rtl/core/qah_pkg.sv
// shared types, constants and arithmetic helpers for the attitude hold block
// used by qah_iter and quaternion_attitude_hold
package qah_pkg;

    localparam int QFB   = 14;
    localparam int EW    = 21;
    localparam int NQW   = 24;
    localparam int RW    = 26;
    localparam int ACCW  = 40;
    localparam int MAW   = 38;
    localparam int MBW   = 28;
    localparam int MPW   = MAW + MBW;
    localparam int SUMW  = 52;
    localparam int RADW  = 52;
    localparam int DENW  = 28;
    localparam int REMW  = 30;
    localparam int TW    = 22;
    localparam int MW    = 27;
    localparam int K0W   = 15;
    localparam int KREMW = 44;

    localparam logic [TW-1:0] TIMER_MAX = '1;
    localparam int SETTLE_RATE16    = 240;
    localparam int SETTLE_MAX_US    = 400000;
    localparam int STALL_RATE16     = 80;
    localparam int STALL_MAX_US     = 3000000;
    localparam int STALL_DEG_Q12    = 20480;
    localparam int DEG_PER_UNIT_Q12 = 469367;
    localparam int STALL_E_LIM      = (STALL_DEG_Q12 * (1 << QFB)) / DEG_PER_UNIT_Q12;
    localparam int RATE_SH          = QFB + 16;
    localparam int DB_MAX           = 1 << QFB;

    localparam logic [15:0] GAIN_RST     = 16'd256;
    localparam logic [14:0] DEADBAND_RST = 15'd1638;
    localparam logic [14:0] MAX_RATE_RST = 15'd3200;
    localparam logic [15:0] LOOP_RST     = 16'd250;

    typedef enum logic [1:0] {
        CFG_GAIN, CFG_DEADBAND, CFG_MAX_RATE, CFG_LOOP_PERIOD
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_TRACK, S_QMUL, S_STALL, S_RATE, S_LIM, S_SQW, S_CEIL,
        S_SCALE, S_DIVW, S_KEEP, S_KROOT, S_KSQ, S_NSQ, S_NROOT, S_NSQW,
        S_NDIV, S_NDIVW, S_FIN
    } state_t;

    typedef enum logic {ITER_SQRT, ITER_DIV} iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_req_t;

    function automatic logic [16:0] abs17(input logic signed [15:0] x);
        logic signed [16:0] w;
        w = 17'(x);
        return x[15] ? 17'(-w) : 17'(w);
    endfunction

    function automatic logic [TW-1:0] tadd(input logic [TW-1:0] t, input logic [15:0] lp);
        logic [TW:0] s;
        s = {1'b0, t} + (TW+1)'(lp);
        return (s > (TW+1)'(TIMER_MAX)) ? TIMER_MAX : s[TW-1:0];
    endfunction

    // sign of each hamilton product term a[i]*b[j^i] in component j
    function automatic logic qneg(input logic [1:0] j, input logic [1:0] i);
        logic n;
        case ({j, i})
            4'h1, 4'h2, 4'h3, 4'h7, 4'h9, 4'hE: n = 1'b1;
            default:                            n = 1'b0;
        endcase
        return n;
    endfunction

    // round half away from zero
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int n);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = v[63] ? 64'(-v) : 64'(v);
        rnd = (mag + (64'd1 << (n - 1))) >> n;
        return v[63] ? -$signed(rnd) : $signed(rnd);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)       r = 16'sh7fff;
        else if (v < -64'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/qah_iter.sv
// bit-serial square root and restoring divider sharing one compare/subtract
// depends on qah_pkg
module qah_iter
    import qah_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  iter_req_t       req,
    input  logic [RADW-1:0] arg,
    input  logic [DENW-1:0] den,
    output logic            done,
    output logic [RADW-1:0] res
);

    localparam int CW = $clog2(RADW + 1);

    logic            busy_reg;
    logic            done_reg;
    iter_op_t        op_reg;
    logic [RADW-1:0] rad_reg;
    logic [RADW-1:0] res_reg;
    logic [REMW-1:0] rem_reg;
    logic [DENW-1:0] den_reg;
    logic [CW-1:0]   cnt_reg;

    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            ge;
    logic [REMW-1:0] rem_next;
    logic [RADW-1:0] rad_next;

    always_comb begin
        if (op_reg == ITER_SQRT) begin
            rem_sh   = {rem_reg[REMW-3:0], rad_reg[RADW-1 -: 2]};
            trial    = {res_reg[REMW-3:0], 2'b01};
            rad_next = rad_reg << 2;
        end else begin
            rem_sh   = {rem_reg[REMW-2:0], rad_reg[RADW-1]};
            trial    = REMW'(den_reg);
            rad_next = rad_reg << 1;
        end
        ge       = rem_sh >= trial;
        rem_next = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                rad_reg  <= arg;
                den_reg  <= den;
                rem_reg  <= '0;
                res_reg  <= '0;
                cnt_reg  <= (req.op == ITER_SQRT) ? CW'(RADW / 2) : CW'(RADW);
            end else if (busy_reg) begin
                rad_reg <= rad_next;
                rem_reg <= rem_next;
                res_reg <= {res_reg[RADW-2:0], ge};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: rtl/core/quaternion_attitude_hold.sv
// quaternion attitude hold: one correction request per control loop update
// depends on qah_pkg and qah_iter
//
// s_ channel takes one request per control loop: attitude quaternion, stick,
// gyro, airborne and engage flags. m_ channel returns one result per request:
// three correction rates and three hold flags. an apb port sets gain,
// deadband, max_rate and loop_period (byte addresses 0, 4, 8, 12).
// one 38x28 multiplier with a registered product and one bit-serial
// sqrt/divide unit do all the arithmetic under a sequencer; s_tready is high
// only while the sequencer is idle. a request with hold inactive skips the
// arithmetic and goes straight to the result; magnitude clamping and target
// recomposition lengthen a held update, mostly in the serial unit.
// a finished result waits in the output register while m_tready is low; the
// sequencer holds in its last step until the register is free.
// reset (aresetn low, synchronous) loads register defaults, an identity
// target, clears all axis flags and timers and empties the output register.
module quaternion_attitude_hold
    import qah_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // att_w, att_x, att_y, att_z, stick_roll, stick_pitch, stick_yaw,
    // gyro_roll, gyro_pitch, gyro_yaw
    input  logic [159:0] s_tdata,
    // airborne, engage
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rate_roll, rate_pitch, rate_yaw
    output logic [47:0]  m_tdata,
    // hold_roll, hold_pitch, hold_yaw
    output logic [2:0]   m_tuser
);

    logic [15:0] gain_reg;
    logic [14:0] deadband_reg;
    logic [14:0] max_rate_reg;
    logic [15:0] loop_period_reg;

    state_t state_reg, state_next;

    logic signed [15:0]  cur_reg [4];
    logic signed [15:0]  stick_reg [3];
    logic signed [15:0]  gyro_reg [3];
    logic                air_reg;
    logic                active_reg;
    logic signed [15:0]  tgt_reg [4];
    logic [2:0]          trk_reg;
    logic [TW-1:0]       settle_reg [3];
    logic [TW-1:0]       stall_reg [3];

    logic [4:0]              cnt_reg;
    logic [1:0]              ax_reg;
    logic                    sel_reg;
    logic signed [ACCW-1:0]  acc_reg;
    logic signed [EW-1:0]    e_reg [4];
    logic signed [NQW-1:0]   nq_reg [4];
    logic signed [RW-1:0]    r_reg [3];
    logic [SUMW-1:0]         sum_reg;
    logic signed [KREMW-1:0] krem_reg;
    logic [K0W-1:0]          keep0_reg;
    logic [MW-1:0]           m_reg;
    logic signed [MPW-1:0]   mul_p_reg;

    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [EW-1:0]  keep_v [4];
    logic [1:0]            axp;
    logic [1:0]            qidx;
    logic [RW-1:0]         r_abs;
    logic                  s_acc;
    logic                  m_free;
    logic                  cfg_wr;

    logic [3:0]             t4;
    logic                   q_neg;
    logic signed [ACCW-1:0] q_term;
    logic signed [ACCW-1:0] q_sum;
    logic signed [63:0]     q_rnd;
    logic signed [63:0]     rate_rnd;

    logic [14:0]         db;
    logic [2:0]          trk_tr;
    logic [TW-1:0]       settle_tr [3];
    logic                e_flip;
    logic signed [EW-1:0] en [4];
    logic [2:0]          trk_st;
    logic [TW-1:0]       settle_st [3];
    logic [TW-1:0]       stall_st [3];

    logic [NQW-1:0]       nq_abs;
    logic signed [63:0]   div_q;
    logic                 krem_pos;
    logic                 any_trk;

    iter_req_t       it_req;
    logic [RADW-1:0] it_arg;
    logic [DENW-1:0] it_den;
    logic            it_done;
    logic [RADW-1:0] it_res;

    qah_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (it_req),
        .arg     (it_arg),
        .den     (it_den),
        .done    (it_done),
        .res     (it_res)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (cfg_idx_t'(paddr[3:2]))
            CFG_GAIN:        prdata = 32'(gain_reg);
            CFG_DEADBAND:    prdata = 32'(deadband_reg);
            CFG_MAX_RATE:    prdata = 32'(max_rate_reg);
            CFG_LOOP_PERIOD: prdata = 32'(loop_period_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg        <= GAIN_RST;
            deadband_reg    <= DEADBAND_RST;
            max_rate_reg    <= MAX_RATE_RST;
            loop_period_reg <= LOOP_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx_t'(paddr[3:2]))
                CFG_GAIN:        gain_reg        <= pwdata[15:0];
                CFG_DEADBAND:    deadband_reg    <= pwdata[14:0];
                CFG_MAX_RATE:    max_rate_reg    <= pwdata[14:0];
                CFG_LOOP_PERIOD: loop_period_reg <= pwdata[15:0];
                default:         gain_reg        <= gain_reg;
            endcase
        end
    end

    assign s_acc   = s_tvalid & s_tready;
    assign m_free  = !m_tvalid_reg || m_tready;
    assign axp     = ax_reg + 2'd1;
    assign qidx    = cnt_reg[3:2] ^ cnt_reg[1:0];
    assign any_trk = |trk_reg;
    assign krem_pos = !krem_reg[KREMW-1] && (krem_reg != '0);

    always_comb begin
        keep_v[0] = EW'($signed({1'b0, keep0_reg}));
        for (int k = 1; k < 4; k++) begin
            keep_v[k] = trk_reg[k-1] ? '0 : e_reg[k];
        end
    end

    assign r_abs = r_reg[ax_reg][RW-1] ? RW'(-r_reg[ax_reg]) : RW'(r_reg[ax_reg]);

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_QMUL: begin
                mul_a = MAW'(cur_reg[cnt_reg[1:0]]);
                mul_b = sel_reg ? MBW'(keep_v[qidx]) : MBW'(tgt_reg[qidx]);
            end
            S_RATE: begin
                case (cnt_reg)
                    5'd0: begin
                        mul_a = MAW'(e_reg[axp]);
                        mul_b = MBW'($signed({1'b0, gain_reg}));
                    end
                    5'd1: begin
                        mul_a = mul_p_reg[MAW-1:0];
                        mul_b = MBW'(DEG_PER_UNIT_Q12);
                    end
                    5'd3: begin
                        mul_a = MAW'(r_reg[ax_reg]);
                        mul_b = MBW'(r_reg[ax_reg]);
                    end
                    default: ;
                endcase
            end
            S_LIM: begin
                mul_a = MAW'($signed({1'b0, max_rate_reg}));
                mul_b = MBW'($signed({1'b0, max_rate_reg}));
            end
            S_CEIL: begin
                mul_a = MAW'($signed({1'b0, m_reg}));
                mul_b = MBW'($signed({1'b0, m_reg}));
            end
            S_SCALE: begin
                mul_a = MAW'($signed({1'b0, r_abs}));
                mul_b = MBW'($signed({1'b0, max_rate_reg}));
            end
            S_KEEP: begin
                mul_a = MAW'(keep_v[axp]);
                mul_b = MBW'(keep_v[axp]);
            end
            S_NSQ: begin
                mul_a = MAW'(nq_reg[cnt_reg[1:0]]);
                mul_b = MBW'(nq_reg[cnt_reg[1:0]]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_a * mul_b;
    end

    // quaternion product accumulation
    always_comb begin
        t4     = 4'(cnt_reg - 5'd1);
        q_neg  = qneg(t4[3:2], t4[1:0]) ^ (!sel_reg && (t4[1:0] != 2'd0));
        q_term = q_neg ? -mul_p_reg[ACCW-1:0] : mul_p_reg[ACCW-1:0];
        q_sum  = ((t4[1:0] == 2'd0) ? '0 : acc_reg) + q_term;
        q_rnd  = rshr(64'(q_sum), QFB);
    end

    assign rate_rnd = air_reg ? rshr(mul_p_reg[63:0], RATE_SH)
                              : rshr(mul_p_reg[63:0], RATE_SH + 2);

    // per-axis tracking update
    always_comb begin
        db = (deadband_reg > 15'(DB_MAX)) ? 15'(DB_MAX) : deadband_reg;
        for (int i = 0; i < 3; i++) begin
            trk_tr[i]    = trk_reg[i];
            settle_tr[i] = settle_reg[i];
            if (abs17(stick_reg[i]) > 17'(db)) begin
                trk_tr[i]    = 1'b1;
                settle_tr[i] = '0;
            end else if (trk_reg[i]) begin
                settle_tr[i] = tadd(settle_reg[i], loop_period_reg);
                if (abs17(gyro_reg[i]) < 17'(SETTLE_RATE16)
                    || settle_tr[i] >= TW'(SETTLE_MAX_US)) begin
                    trk_tr[i] = 1'b0;
                end
            end
        end
    end

    // error sign fix and stall detection
    always_comb begin
        e_flip = e_reg[0][EW-1];
        for (int k = 0; k < 4; k++) begin
            en[k] = e_flip ? -e_reg[k] : e_reg[k];
        end
        for (int i = 0; i < 3; i++) begin
            trk_st[i]    = trk_reg[i];
            settle_st[i] = settle_reg[i];
            stall_st[i]  = '0;
            if (!trk_reg[i]
                && (en[i+1][EW-1] ? EW'(-en[i+1]) : EW'(en[i+1])) > EW'(STALL_E_LIM)
                && abs17(gyro_reg[i]) < 17'(STALL_RATE16)) begin
                stall_st[i] = tadd(stall_reg[i], loop_period_reg);
                if (stall_st[i] >= TW'(STALL_MAX_US)) begin
                    trk_st[i]    = 1'b1;
                    settle_st[i] = '0;
                    stall_st[i]  = '0;
                end
            end
        end
    end

    assign nq_abs = nq_reg[ax_reg][NQW-1] ? NQW'(-nq_reg[ax_reg]) : NQW'(nq_reg[ax_reg]);
    assign div_q  = $signed({12'b0, it_res});

    // serial unit requests
    always_comb begin
        it_req.start = 1'b0;
        it_req.op    = ITER_SQRT;
        it_arg       = sum_reg;
        it_den       = DENW'(m_reg);
        unique case (state_reg)
            S_LIM: begin
                it_req.start = (cnt_reg == 5'd1) && (sum_reg > SUMW'(mul_p_reg[29:0]));
            end
            S_SCALE: begin
                it_req.start = (cnt_reg == 5'd1) && !trk_reg[ax_reg];
                it_req.op    = ITER_DIV;
                it_arg       = mul_p_reg[RADW-1:0];
            end
            S_KROOT: begin
                it_req.start = krem_pos;
                it_arg       = RADW'(krem_reg[KREMW-2:0]);
            end
            S_NROOT: begin
                it_req.start = 1'b1;
            end
            S_NDIV: begin
                it_req.start = 1'b1;
                it_req.op    = ITER_DIV;
                it_arg       = (RADW'(nq_abs) << QFB) + RADW'(m_reg >> 1);
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) state_next = S_TRACK;
            end
            S_TRACK: state_next = active_reg ? S_QMUL : S_FIN;
            S_QMUL: begin
                if (cnt_reg == 5'd16) state_next = sel_reg ? S_NSQ : S_STALL;
            end
            S_STALL: state_next = S_RATE;
            S_RATE: begin
                if (cnt_reg == 5'd4 && ax_reg == 2'd2) state_next = S_LIM;
            end
            S_LIM: begin
                if (cnt_reg == 5'd1) begin
                    if (it_req.start) state_next = S_SQW;
                    else              state_next = any_trk ? S_KEEP : S_FIN;
                end
            end
            S_SQW: if (it_done) state_next = S_CEIL;
            S_CEIL: if (cnt_reg == 5'd1) state_next = S_SCALE;
            S_SCALE: begin
                if (trk_reg[ax_reg]) begin
                    if (ax_reg == 2'd2) state_next = any_trk ? S_KEEP : S_FIN;
                end else if (cnt_reg == 5'd1) begin
                    state_next = S_DIVW;
                end
            end
            S_DIVW: begin
                if (it_done) begin
                    if (ax_reg == 2'd2) state_next = any_trk ? S_KEEP : S_FIN;
                    else                state_next = S_SCALE;
                end
            end
            S_KEEP: begin
                if (cnt_reg == 5'd1 && ax_reg == 2'd2) state_next = S_KROOT;
            end
            S_KROOT: state_next = krem_pos ? S_KSQ : S_QMUL;
            S_KSQ: if (it_done) state_next = S_QMUL;
            S_NSQ: if (cnt_reg == 5'd4) state_next = S_NROOT;
            S_NROOT: state_next = S_NSQW;
            S_NSQW: begin
                if (it_done) state_next = (it_res == '0) ? S_FIN : S_NDIV;
            end
            S_NDIV: state_next = S_NDIVW;
            S_NDIVW: begin
                if (it_done) state_next = (ax_reg == 2'd3) ? S_FIN : S_NDIV;
            end
            S_FIN: if (m_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            trk_reg    <= '0;
            tgt_reg[0] <= 16'(DB_MAX);
            for (int k = 1; k < 4; k++) tgt_reg[k] <= '0;
            for (int i = 0; i < 3; i++) begin
                settle_reg[i] <= '0;
                stall_reg[i]  <= '0;
            end
            cnt_reg <= '0;
            ax_reg  <= '0;
            sel_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        for (int k = 0; k < 4; k++) cur_reg[k] <= s_tdata[16*k +: 16];
                        for (int i = 0; i < 3; i++) begin
                            stick_reg[i] <= s_tdata[64 + 16*i +: 16];
                            gyro_reg[i]  <= s_tdata[112 + 16*i +: 16];
                        end
                        air_reg    <= s_tuser[0];
                        active_reg <= s_tuser[1];
                        if (s_tuser[1] && !active_reg) begin
                            for (int k = 0; k < 4; k++) tgt_reg[k] <= s_tdata[16*k +: 16];
                            trk_reg <= '0;
                            for (int i = 0; i < 3; i++) begin
                                settle_reg[i] <= '0;
                                stall_reg[i]  <= '0;
                            end
                        end
                    end
                end
                S_TRACK: begin
                    if (active_reg) begin
                        trk_reg    <= trk_tr;
                        settle_reg <= settle_tr;
                    end
                    cnt_reg <= '0;
                    sel_reg <= 1'b0;
                end
                S_QMUL: begin
                    if (cnt_reg != 5'd0) begin
                        acc_reg <= q_sum;
                        if (t4[1:0] == 2'd3) begin
                            if (sel_reg) nq_reg[t4[3:2]] <= q_rnd[NQW-1:0];
                            else         e_reg[t4[3:2]]  <= q_rnd[EW-1:0];
                        end
                    end
                    cnt_reg <= (cnt_reg == 5'd16) ? 5'd0 : cnt_reg + 5'd1;
                    sum_reg <= '0;
                    ax_reg  <= '0;
                end
                S_STALL: begin
                    e_reg      <= en;
                    trk_reg    <= trk_st;
                    settle_reg <= settle_st;
                    stall_reg  <= stall_st;
                    cnt_reg    <= '0;
                    ax_reg     <= '0;
                end
                S_RATE: begin
                    if (cnt_reg == 5'd2) r_reg[ax_reg] <= rate_rnd[RW-1:0];
                    if (cnt_reg == 5'd4) begin
                        if (!trk_reg[ax_reg]) sum_reg <= sum_reg + mul_p_reg[SUMW-1:0];
                        ax_reg  <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                        cnt_reg <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_LIM: begin
                    cnt_reg  <= (cnt_reg == 5'd1) ? 5'd0 : cnt_reg + 5'd1;
                    ax_reg   <= '0;
                    krem_reg <= KREMW'(1) << (2 * QFB);
                end
                S_SQW: begin
                    if (it_done) m_reg <= it_res[MW-1:0];
                    cnt_reg <= '0;
                end
                S_CEIL: begin
                    if (cnt_reg == 5'd1) begin
                        if (mul_p_reg[SUMW-1:0] < sum_reg) m_reg <= m_reg + MW'(1);
                        cnt_reg <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                    ax_reg <= '0;
                end
                S_SCALE: begin
                    if (trk_reg[ax_reg]) begin
                        ax_reg  <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                        cnt_reg <= '0;
                    end else begin
                        cnt_reg <= (cnt_reg == 5'd1) ? 5'd0 : cnt_reg + 5'd1;
                    end
                end
                S_DIVW: begin
                    if (it_done) begin
                        r_reg[ax_reg] <= r_reg[ax_reg][RW-1] ? -div_q[RW-1:0] : div_q[RW-1:0];
                        ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                    end
                end
                S_KEEP: begin
                    if (cnt_reg == 5'd1) begin
                        krem_reg <= krem_reg - mul_p_reg[KREMW-1:0];
                        ax_reg   <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                        cnt_reg  <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_KROOT: begin
                    keep0_reg <= '0;
                    sel_reg   <= 1'b1;
                    cnt_reg   <= '0;
                end
                S_KSQ: begin
                    if (it_done) keep0_reg <= it_res[K0W-1:0];
                end
                S_NSQ: begin
                    if (cnt_reg != 5'd0) sum_reg <= sum_reg + mul_p_reg[SUMW-1:0];
                    cnt_reg <= (cnt_reg == 5'd4) ? 5'd0 : cnt_reg + 5'd1;
                    ax_reg  <= '0;
                end
                S_NSQW: begin
                    if (it_done) m_reg <= it_res[MW-1:0];
                end
                S_NDIVW: begin
                    if (it_done) begin
                        tgt_reg[ax_reg] <= sat16(nq_reg[ax_reg][NQW-1] ? -div_q : div_q);
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            if (state_reg == S_FIN && m_free) begin
                m_tvalid_reg <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    m_tuser_reg[i] <= active_reg & !trk_reg[i];
                    m_tdata_reg[16*i +: 16] <= (active_reg & !trk_reg[i])
                                               ? sat16(64'(r_reg[i])) : 16'd0;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
